// ===== hw/rtl/rcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcd_pkg
// shared types, widths and codes for the command deframer
// ----------------------------------------------------------------------------
package rcd_pkg;

    localparam int LENGTH_BITS   = 32;
    localparam int COUNT_BITS    = 16;
    localparam int ACC_BITS      = 33;
    localparam int WIDE_BITS     = ACC_BITS + 4;
    localparam int ELEM_NUM_BITS = 16;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 32;
    localparam int OUT_DATA_BITS = 32;

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_BULK  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_COUNT = 8'd1;

    localparam logic [31:0] MAX_BULK_RESET  = 32'd536870912;
    localparam logic [15:0] MAX_COUNT_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_PREFIX     = 3'd1,
        ERR_NO_DIGITS  = 3'd2,
        ERR_NEGATIVE   = 3'd3,
        ERR_TOO_LARGE  = 3'd4,
        ERR_ELEM_TYPE  = 3'd5
    } err_t;

    typedef struct packed {
        logic stop;
        logic digit;
        logic neg;
    } len_flags_t;

    typedef struct packed {
        logic fail;
        err_t err;
        logic is_zero;
    } len_judge_t;

    typedef struct packed {
        logic [7:0]               out_byte;
        logic                     byte_valid;
        logic                     element_end;
        logic                     command_end;
        logic [ELEM_NUM_BITS-1:0] element_number;
        err_t                     error_code;
    } res_t;

endpackage

// ===== hw/rtl/resp_command_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// resp_command_deframer_unit
// byte-serial deframer for simple strings, bulk strings and string arrays
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one protocol byte per transaction in tdata[7:0]
//   m_axis carries zero or one result per input byte: a payload byte
//   (tuser[0]), an element end marker (tuser[1]) or an error code; tlast
//   marks the end of a whole command
//   the cfg channel writes the bulk length limit (index 0) and the array
//   count limit (index 1); it is always ready; the user must write it only
//   while idle (unenforced); a result appears in the cycle after its byte
//   throughput: one byte per cycle, set by the single parse state update
//   the result register holds while m_axis_tready is low; s_axis_tready
//   stays high as long as the result register is empty or being drained
//   reset returns the parser to expecting a top-level prefix and restores
//   the default limits; no clearing pass is needed
// ----------------------------------------------------------------------------
module resp_command_deframer_unit
    import rcd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // in_byte
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // out_byte, element_number, error_code
    output logic [1:0]               m_axis_tuser,   // byte_valid, element_end
    output logic                     m_axis_tlast,   // command_end
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [31:0] max_bulk;
    logic [15:0] max_count;
    res_t        res;

    rcd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .max_bulk  (max_bulk),
        .max_count (max_count)
    );

    rcd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res),
        .max_bulk  (max_bulk),
        .max_count (max_count)
    );

    assign m_axis_tdata = OUT_DATA_BITS'({res.error_code, res.element_number, res.out_byte});
    assign m_axis_tuser = {res.element_end, res.byte_valid};
    assign m_axis_tlast = res.command_end;

endmodule

// ===== hw/rtl/rcd_len_unit.sv =====
// ----------------------------------------------------------------------------
// rcd_len_unit
// decimal length line: digit accumulation with saturation and final checks
// ----------------------------------------------------------------------------
module rcd_len_unit
    import rcd_pkg::*;
(
    input  logic [ACC_BITS-1:0] acc,
    input  len_flags_t          flags,
    input  logic [7:0]          in_byte,
    input  logic                to_array,
    input  logic [31:0]         max_bulk,
    input  logic [15:0]         max_count,
    output logic [ACC_BITS-1:0] acc_step,
    output len_flags_t          flags_step,
    output len_judge_t          judge
);

    logic [WIDE_BITS-1:0] wide;
    logic [3:0]           digit;
    logic                 is_digit;

    assign is_digit = (in_byte inside {[CH_ZERO:CH_NINE]});
    assign digit    = 4'(in_byte - CH_ZERO);
    assign wide     = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + WIDE_BITS'(digit);

    // one character of the length line
    always_comb
    begin
        acc_step   = acc;
        flags_step = flags;
        if (!flags.stop)
        begin
            if (is_digit)
            begin
                flags_step.digit = 1'b1;
                if (wide[WIDE_BITS-1:ACC_BITS] != '0)
                    acc_step = '1;
                else
                    acc_step = wide[ACC_BITS-1:0];
            end
            else
            begin
                flags_step.stop = 1'b1;
            end
        end
    end

    // judgement after the line terminator
    always_comb
    begin
        judge.fail    = 1'b0;
        judge.err     = ERR_NONE;
        judge.is_zero = (acc == '0);
        if (!flags.digit)
        begin
            judge.fail = 1'b1;
            judge.err  = ERR_NO_DIGITS;
        end
        else if (flags.neg && !judge.is_zero)
        begin
            judge.fail = 1'b1;
            judge.err  = ERR_NEGATIVE;
        end
        else if (!to_array)
        begin
            if ((acc > ACC_BITS'(max_bulk)) || ((acc >> LENGTH_BITS) != '0))
            begin
                judge.fail = 1'b1;
                judge.err  = ERR_TOO_LARGE;
            end
        end
        else
        begin
            if ((acc > ACC_BITS'(max_count)) || ((acc >> COUNT_BITS) != '0))
            begin
                judge.fail = 1'b1;
                judge.err  = ERR_TOO_LARGE;
            end
        end
    end

endmodule

// ===== hw/rtl/rcd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rcd_cfg_regs
// configuration registers for the length limits
// ----------------------------------------------------------------------------
module rcd_cfg_regs
    import rcd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output logic [31:0]              max_bulk,
    output logic [15:0]              max_count
);

    logic [31:0] max_bulk_reg;
    logic [15:0] max_count_reg;

    assign cfg_ready = 1'b1;
    assign max_bulk  = max_bulk_reg;
    assign max_count = max_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bulk_reg  <= MAX_BULK_RESET;
            max_count_reg <= MAX_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_BULK:  max_bulk_reg  <= 32'(cfg_data);
                CFG_MAX_COUNT: max_count_reg <= 16'(cfg_data);
                default:       ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/rcd_parser.sv =====
// ----------------------------------------------------------------------------
// rcd_parser
// per-byte parse state machine with the result register
// ----------------------------------------------------------------------------
module rcd_parser
    import rcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        out_res,
    input  logic [31:0] max_bulk,
    input  logic [15:0] max_count
);

    typedef enum logic [3:0] {
        PH_PREFIX,
        PH_SIMPLE,
        PH_LEN_START,
        PH_LEN_BODY,
        PH_LEN_LF,
        PH_BULK,
        PH_BULK_TAIL,
        PH_SKIP,
        PH_ELEM_PREFIX
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [ACC_BITS-1:0]     acc_reg, acc_next;
    len_flags_t              flags_reg, flags_next;
    logic [LENGTH_BITS-1:0]  payload_reg, payload_next;
    logic [COUNT_BITS-1:0]   elems_reg, elems_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic                    in_array_reg, in_array_next;
    logic                    to_array_reg, to_array_next;
    logic                    res_valid_reg, res_valid_next;
    res_t                    res_reg, res_next;

    logic [ACC_BITS-1:0]     acc_step;
    len_flags_t              flags_step;
    len_judge_t              judge;
    logic                    accept;
    logic                    emit;
    res_t                    res_calc;

    rcd_len_unit u_len (
        .acc        (acc_reg),
        .flags      (flags_reg),
        .in_byte    (in_byte),
        .to_array   (to_array_reg),
        .max_bulk   (max_bulk),
        .max_count  (max_count),
        .acc_step   (acc_step),
        .flags_step (flags_step),
        .judge      (judge)
    );

    assign in_ready  = !res_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = res_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        acc_next      = acc_reg;
        flags_next    = flags_reg;
        payload_next  = payload_reg;
        elems_next    = elems_reg;
        count_next    = count_reg;
        in_array_next = in_array_reg;
        to_array_next = to_array_reg;
        emit          = 1'b0;
        res_calc      = '0;
        res_calc.element_number = ELEM_NUM_BITS'(count_reg);

        case (phase_reg)
            PH_PREFIX:
            begin
                in_array_next = 1'b0;
                count_next    = '0;
                res_calc.element_number = '0;
                if (in_byte == CH_PLUS)
                    phase_next = PH_SIMPLE;
                else if (in_byte inside {CH_DOLLAR, CH_STAR})
                begin
                    to_array_next = (in_byte == CH_STAR);
                    acc_next      = '0;
                    flags_next    = '0;
                    phase_next    = PH_LEN_START;
                end
                else
                begin
                    emit                = 1'b1;
                    res_calc.error_code = ERR_PREFIX;
                    phase_next          = PH_PREFIX;
                    elems_next          = '0;
                end
            end
            PH_ELEM_PREFIX:
            begin
                if (in_byte == CH_PLUS)
                    phase_next = PH_SIMPLE;
                else if (in_byte == CH_DOLLAR)
                begin
                    to_array_next = 1'b0;
                    acc_next      = '0;
                    flags_next    = '0;
                    phase_next    = PH_LEN_START;
                end
                else
                begin
                    emit                = 1'b1;
                    res_calc.error_code = ERR_ELEM_TYPE;
                    phase_next          = PH_PREFIX;
                    in_array_next       = 1'b0;
                    elems_next          = '0;
                    count_next          = '0;
                end
            end
            PH_SIMPLE, PH_BULK_TAIL:
            begin
                if (phase_reg == PH_SIMPLE && in_byte != CH_CR)
                begin
                    emit                = 1'b1;
                    res_calc.out_byte   = in_byte;
                    res_calc.byte_valid = 1'b1;
                end
                else
                begin
                    // end of string element
                    emit                 = 1'b1;
                    res_calc.element_end = 1'b1;
                    res_calc.command_end = 1'b1;
                    phase_next           = PH_SKIP;
                    if (in_array_reg)
                    begin
                        elems_next = elems_reg - 1'b1;
                        count_next = count_reg + 1'b1;
                        if (elems_next != '0)
                            res_calc.command_end = 1'b0;
                        else
                        begin
                            in_array_next = 1'b0;
                            count_next    = '0;
                        end
                    end
                end
            end
            PH_LEN_START:
            begin
                phase_next = PH_LEN_BODY;
                if (in_byte == CH_CR)
                    phase_next = PH_LEN_LF;
                else if (in_byte == CH_MINUS)
                    flags_next.neg = 1'b1;
                else if (in_byte != CH_PLUS)
                begin
                    acc_next   = acc_step;
                    flags_next = flags_step;
                end
            end
            PH_LEN_BODY:
            begin
                if (in_byte == CH_CR)
                    phase_next = PH_LEN_LF;
                else
                begin
                    acc_next   = acc_step;
                    flags_next = flags_step;
                end
            end
            PH_LEN_LF:
            begin
                if (judge.fail)
                begin
                    emit                = 1'b1;
                    res_calc.error_code = judge.err;
                    phase_next          = PH_PREFIX;
                    in_array_next       = 1'b0;
                    elems_next          = '0;
                    count_next          = '0;
                end
                else if (!to_array_reg)
                begin
                    payload_next = LENGTH_BITS'(acc_reg);
                    phase_next   = judge.is_zero ? PH_BULK_TAIL : PH_BULK;
                end
                else
                begin
                    count_next = '0;
                    res_calc.element_number = '0;
                    if (judge.is_zero)
                    begin
                        // empty array ends the command at once
                        emit                 = 1'b1;
                        res_calc.command_end = 1'b1;
                        phase_next           = PH_PREFIX;
                    end
                    else
                    begin
                        elems_next    = COUNT_BITS'(acc_reg);
                        in_array_next = 1'b1;
                        phase_next    = PH_ELEM_PREFIX;
                    end
                end
            end
            PH_BULK:
            begin
                payload_next = payload_reg - 1'b1;
                if (payload_next == '0)
                    phase_next = PH_BULK_TAIL;
                emit                = 1'b1;
                res_calc.out_byte   = in_byte;
                res_calc.byte_valid = 1'b1;
            end
            PH_SKIP:
            begin
                phase_next = in_array_reg ? PH_ELEM_PREFIX : PH_PREFIX;
            end
            default:
            begin
                phase_next = PH_PREFIX;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (accept)
        begin
            res_valid_next = emit;
            if (emit)
                res_next = res_calc;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PREFIX;
            acc_reg       <= '0;
            flags_reg     <= '0;
            payload_reg   <= '0;
            elems_reg     <= '0;
            count_reg     <= '0;
            in_array_reg  <= 1'b0;
            to_array_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                acc_reg      <= acc_next;
                flags_reg    <= flags_next;
                payload_reg  <= payload_next;
                elems_reg    <= elems_next;
                count_reg    <= count_next;
                in_array_reg <= in_array_next;
                to_array_reg <= to_array_next;
            end
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

endmodule
